/* hw/rtl/lmfe_pkg.sv */
`default_nettype none
package lmfe_pkg;

    localparam int COLUMNS  = 16;
    localparam int COLUMN_W = 4;
    localparam int FILL_W   = $clog2(COLUMNS + 1);

    localparam logic [2:0] MODE_LOAD   = 3'd0;
    localparam logic [2:0] MODE_SCROLL = 3'd1;
    localparam logic [2:0] MODE_FILL   = 3'd2;
    localparam logic [2:0] MODE_CLEAR  = 3'd3;

    localparam logic [15:0] NOISE_SEED = 16'hACE1;

    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
    } t_cell_ctrl;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
    } t_column;

    // fibonacci step, taps 0 2 3 5
    function automatic logic [15:0] lfsr_step(input logic [15:0] r);
        lfsr_step = {r[0] ^ r[2] ^ r[3] ^ r[5], r[15:1]};
    endfunction

    function automatic logic [7:0] red_scramble(input logic [7:0] v);
        red_scramble = {v[5], v[6], v[7], v[4], v[2], v[0], v[1], v[3]};
    endfunction

    function automatic logic [7:0] green_scramble(input logic [7:0] v);
        green_scramble = {v[6], v[5], v[4], v[7], v[0], v[1], v[2], v[3]};
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/lmfe_cell.sv */
`default_nettype none
module lmfe_cell
    import lmfe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_column    i_load,
    input  wire t_column    i_shift_in,
    output t_column         o_column
);

    t_column r_column;
    t_column n_column;

    always_comb begin
        priority if (i_ctrl.clear) begin
            n_column = '0;
        end else if (i_ctrl.load) begin
            n_column = i_load;
        end else if (i_ctrl.shift) begin
            n_column = i_shift_in;
        end else begin
            n_column = r_column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
        end else begin
            r_column <= n_column;
        end
    end

    assign o_column = r_column;

endmodule
`default_nettype wire

/* hw/rtl/lmfe_noise.sv */
`default_nettype none
module lmfe_noise
    import lmfe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    output t_column   o_column
);

    logic [15:0] r_lfsr;
    logic [15:0] w_s1;
    logic [15:0] w_s2;
    logic [15:0] n_lfsr;

    always_comb begin
        w_s1   = lfsr_step(r_lfsr);
        w_s2   = lfsr_step(w_s1);
        n_lfsr = i_step ? lfsr_step(w_s2) : r_lfsr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= NOISE_SEED;
        end else begin
            r_lfsr <= n_lfsr;
        end
    end

    assign o_column.red   = red_scramble(w_s1[7:0]);
    assign o_column.green = green_scramble(w_s2[7:0]);

endmodule
`default_nettype wire

/* hw/rtl/led_matrix_frame_engine.sv */
`default_nettype none
// two-color 8-row led frame buffer held as a chain of column cells
// a request is taken at a clock edge with start high and busy low; its fields are
// i_mode, i_column, i_red_bits and i_green_bits
// load, scroll, clear and read update the chain at the accepting edge and the
// addressed column is registered at the next edge: o_valid is high for one cycle,
// two cycles after the request, and busy is high in between
// a new request may be taken in the same cycle that o_valid is high, so these
// modes run at one request every two cycles
// random fill shifts one noise column into the top cell per cycle, the lfsr
// stepping three times per cycle, so it takes COLUMNS cycles plus two to o_valid
// a column outside the buffer reads as zero and a load to it writes nothing
// reset clears every cell, reloads the lfsr seed and drops any request in flight
// results are a one-cycle strobe that the receiver must take when it appears
module led_matrix_frame_engine
    import lmfe_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [2:0]          i_mode,
    input  wire logic [COLUMN_W-1:0] i_column,
    input  wire logic [7:0]          i_red_bits,
    input  wire logic [7:0]          i_green_bits,
    output logic                     o_valid,
    output logic [7:0]               o_red_column,
    output logic [7:0]               o_green_column
);

    logic                r_pend;
    logic [FILL_W-1:0]   r_fill_cnt;
    logic [COLUMN_W-1:0] r_col;
    logic                r_valid;
    logic [7:0]          r_red_out;
    logic [7:0]          r_green_out;

    logic       w_accept;
    logic       w_filling;
    t_column    w_in_col;
    t_column    w_noise;
    t_column    w_top_in;
    t_column    w_sel;
    t_column    w_cells [COLUMNS];
    t_cell_ctrl w_ctrl  [COLUMNS];

    assign w_accept  = start && !busy;
    assign w_filling = (r_fill_cnt != '0);
    assign busy      = r_pend || w_filling;
    assign w_in_col  = '{red: i_red_bits, green: i_green_bits};
    assign w_top_in  = w_filling ? w_noise : w_in_col;

    lmfe_noise u_noise (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_filling),
        .o_column (w_noise)
    );

    for (genvar k = 0; k < COLUMNS; k++) begin : g_cell
        localparam int K = k;

        assign w_ctrl[k].load  = w_accept && (i_mode == MODE_LOAD)
                                 && (32'(i_column) == K);
        assign w_ctrl[k].shift = (w_accept && (i_mode == MODE_SCROLL)) || w_filling;
        assign w_ctrl[k].clear = w_accept && (i_mode == MODE_CLEAR);

        lmfe_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl[k]),
            .i_load     (w_in_col),
            .i_shift_in ((K == COLUMNS - 1) ? w_top_in : w_cells[(K + 1) % COLUMNS]),
            .o_column   (w_cells[k])
        );
    end

    always_comb begin
        w_sel = '0;
        for (int k = 0; k < COLUMNS; k++) begin
            if (32'(r_col) == k) begin
                w_sel = w_cells[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= 1'b0;
            r_fill_cnt <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= r_pend;
            if (w_accept) begin
                if (i_mode == MODE_FILL) begin
                    r_fill_cnt <= FILL_W'(COLUMNS);
                    r_pend     <= 1'b0;
                end else begin
                    r_pend <= 1'b1;
                end
            end else if (w_filling) begin
                r_fill_cnt <= r_fill_cnt - FILL_W'(1);
                r_pend     <= (r_fill_cnt == FILL_W'(1));
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_col <= i_column;
        end
        if (r_pend) begin
            r_red_out   <= w_sel.red;
            r_green_out <= w_sel.green;
        end
    end

    assign o_valid        = r_valid;
    assign o_red_column   = r_red_out;
    assign o_green_column = r_green_out;

    a_pend_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> o_valid)
        else $error("pending request did not produce a result");

    a_pend_fill_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && w_filling))
        else $error("result pending while fill still running");

    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy while result strobe is out");

    a_clear_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_mode == MODE_CLEAR) |=> ##1
            (o_valid && o_red_column == 8'd0 && o_green_column == 8'd0))
        else $error("clear did not return a dark column");

endmodule
`default_nettype wire

/* test/tb_led_matrix_frame_engine.sv */
`default_nettype none
module tb_led_matrix_frame_engine;
    import lmfe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_READ       = 3'd4;
    localparam logic [2:0] MODE_UNUSED_LO  = 3'd5;
    localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI  = 3'd7;
    localparam int RANDOM_REQUESTS = 1100;
    localparam int DRAIN_CYCLES    = COLUMNS + 8;

    typedef struct packed {
        logic [2:0]          mode;
        logic [COLUMN_W-1:0] column;
        logic [7:0]          red;
        logic [7:0]          green;
    } t_frame_req;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic [2:0]          i_mode         = '0;
    logic [COLUMN_W-1:0] i_column       = '0;
    logic [7:0]          i_red_bits     = '0;
    logic [7:0]          i_green_bits   = '0;
    logic                busy;
    logic                o_valid;
    logic [7:0]          o_red_column;
    logic [7:0]          o_green_column;

    led_matrix_frame_engine u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_column       (i_column),
        .i_red_bits     (i_red_bits),
        .i_green_bits   (i_green_bits),
        .o_valid        (o_valid),
        .o_red_column   (o_red_column),
        .o_green_column (o_green_column)
    );

    t_frame_req  pending_reqs[$];
    t_column     column_expect[$];
    logic [7:0]  red_buf[COLUMNS];
    logic [7:0]  green_buf[COLUMNS];
    logic [15:0] noise_q;
    logic        req_taken = 1'b0;
    int          gap_left  = 0;
    int          burst_left = 0;
    int          error_count = 0;
    int          result_count = 0;
    int          mode_count[8];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] noise_next(input logic [15:0] r);
        logic fb;
        fb = r[0] ^ r[2] ^ r[3] ^ r[5];
        return {fb, r[15:1]};
    endfunction

    // row n of the column comes from source bit src[n], row 0 in bit 7
    function automatic logic [7:0] mix_bits(input logic [7:0] v, input int src[8]);
        logic [7:0] res;
        res = '0;
        for (int row = 0; row < 8; row++) begin
            res[7-row] = v[src[row]];
        end
        return res;
    endfunction

    function automatic t_column frame_update(input t_frame_req rq);
        t_column res;
        int      red_src[8];
        int      green_src[8];
        red_src   = '{5, 6, 7, 4, 2, 0, 1, 3};
        green_src = '{6, 5, 4, 7, 0, 1, 2, 3};
        case (rq.mode)
            MODE_LOAD: begin
                if (rq.column < COLUMNS) begin
                    red_buf[rq.column]   = rq.red;
                    green_buf[rq.column] = rq.green;
                end
            end
            MODE_SCROLL: begin
                for (int k = 0; k < COLUMNS - 1; k++) begin
                    red_buf[k]   = red_buf[k+1];
                    green_buf[k] = green_buf[k+1];
                end
                red_buf[COLUMNS-1]   = rq.red;
                green_buf[COLUMNS-1] = rq.green;
            end
            MODE_FILL: begin
                for (int k = 0; k < COLUMNS; k++) begin
                    noise_q      = noise_next(noise_q);
                    red_buf[k]   = mix_bits(noise_q[7:0], red_src);
                    noise_q      = noise_next(noise_q);
                    green_buf[k] = mix_bits(noise_q[7:0], green_src);
                    noise_q      = noise_next(noise_q);
                end
            end
            MODE_CLEAR: begin
                for (int k = 0; k < COLUMNS; k++) begin
                    red_buf[k]   = '0;
                    green_buf[k] = '0;
                end
            end
            default: begin
            end
        endcase
        if (rq.column < COLUMNS) begin
            res.red   = red_buf[rq.column];
            res.green = green_buf[rq.column];
        end else begin
            res = '0;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 4) begin
            burst_left = $urandom_range(60, 20);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        error_count++;
        $display("%0t: %s mismatch on result %0d: expected %02h got %02h",
                 $realtime, what, result_count, exp_v, got_v);
    endtask

    task automatic queue_req(input logic [2:0] mode, input logic [COLUMN_W-1:0] column,
                             input logic [7:0] red, input logic [7:0] green);
        t_frame_req rq;
        rq.mode   = mode;
        rq.column = column;
        rq.red    = red;
        rq.green  = green;
        pending_reqs.push_back(rq);
    endtask

    // request acceptance and result checking
    always @(posedge i_clk) begin
        t_frame_req rq;
        t_column    exp_col;
        if (i_rst_n && o_valid) begin
            if (column_expect.size() == 0) begin
                report_mismatch("unexpected result", 0, o_red_column);
            end else begin
                exp_col = column_expect.pop_front();
                if (o_red_column !== exp_col.red)
                    report_mismatch("red_column", exp_col.red, o_red_column);
                if (o_green_column !== exp_col.green)
                    report_mismatch("green_column", exp_col.green, o_green_column);
            end
            result_count++;
        end
        if (i_rst_n && start && !busy) begin
            rq.mode   = i_mode;
            rq.column = i_column;
            rq.red    = i_red_bits;
            rq.green  = i_green_bits;
            column_expect.push_back(frame_update(rq));
            mode_count[rq.mode]++;
            req_taken <= 1'b1;
        end else begin
            req_taken <= 1'b0;
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_frame_req rq;
        if (i_rst_n) begin
            if (start && !req_taken) begin
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                rq = pending_reqs.pop_front();
                start        <= 1'b1;
                i_mode       <= rq.mode;
                i_column     <= rq.column;
                i_red_bits   <= rq.red;
                i_green_bits <= rq.green;
                gap_left = pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    initial begin
        #5ms;
        $display("tb_led_matrix_frame_engine NOT OK");
        $finish;
    end

    initial begin
        int                  roll;
        logic [2:0]          rnd_mode;
        logic [COLUMN_W-1:0] rnd_column;
        logic [7:0]          rnd_red;
        logic [7:0]          rnd_green;
        for (int k = 0; k < COLUMNS; k++) begin
            red_buf[k]   = '0;
            green_buf[k] = '0;
        end
        for (int k = 0; k < 8; k++) mode_count[k] = 0;
        noise_q = NOISE_SEED;

        // directed
        queue_req(MODE_READ, 4'd0, 8'hFF, 8'hFF);
        queue_req(MODE_READ, 4'd15, 8'h00, 8'h00);
        queue_req(MODE_LOAD, 4'd0, 8'hFF, 8'h00);
        queue_req(MODE_LOAD, 4'd15, 8'h00, 8'hFF);
        queue_req(MODE_LOAD, 4'd7, 8'hA5, 8'h5A);
        queue_req(MODE_READ, 4'd7, 8'h00, 8'h00);
        queue_req(MODE_READ, 4'd0, 8'h00, 8'h00);
        queue_req(MODE_SCROLL, 4'd15, 8'h81, 8'h7E);
        queue_req(MODE_SCROLL, 4'd0, 8'h01, 8'h80);
        queue_req(MODE_READ, 4'd6, 8'h00, 8'h00);
        queue_req(MODE_READ, 4'd14, 8'h00, 8'h00);
        queue_req(MODE_FILL, 4'd0, 8'h00, 8'h00);
        queue_req(MODE_READ, 4'd15, 8'h00, 8'h00);
        queue_req(MODE_FILL, 4'd15, 8'hFF, 8'hFF);
        queue_req(MODE_READ, 4'd8, 8'h00, 8'h00);
        queue_req(MODE_CLEAR, 4'd8, 8'hFF, 8'hFF);
        queue_req(MODE_READ, 4'd0, 8'h00, 8'h00);
        queue_req(MODE_FILL, 4'd3, 8'h00, 8'h00);
        queue_req(MODE_UNUSED_LO, 4'd3, 8'hFF, 8'hFF);
        queue_req(MODE_UNUSED_MID, 4'd12, 8'h55, 8'hAA);
        queue_req(MODE_UNUSED_HI, 4'd0, 8'hAA, 8'h55);
        queue_req(MODE_LOAD, 4'd9, 8'h00, 8'h00);
        queue_req(MODE_SCROLL, 4'd9, 8'hFF, 8'hFF);
        queue_req(MODE_CLEAR, 4'd15, 8'h00, 8'h00);

        // random
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            roll       = $urandom_range(99);
            rnd_column = COLUMN_W'($urandom_range(COLUMNS - 1));
            rnd_red    = 8'($urandom_range(255));
            rnd_green  = 8'($urandom_range(255));
            if (roll < 30)
                rnd_mode = MODE_LOAD;
            else if (roll < 55)
                rnd_mode = MODE_SCROLL;
            else if (roll < 63)
                rnd_mode = MODE_FILL;
            else if (roll < 68)
                rnd_mode = MODE_CLEAR;
            else if (roll < 93)
                rnd_mode = MODE_READ;
            else
                rnd_mode = 3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
            queue_req(rnd_mode, rnd_column, rnd_red, rnd_green);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || start) @(posedge i_clk);
        while (column_expect.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d results: load %0d scroll %0d fill %0d clear %0d read %0d",
                 result_count, mode_count[MODE_LOAD], mode_count[MODE_SCROLL],
                 mode_count[MODE_FILL], mode_count[MODE_CLEAR], mode_count[MODE_READ]);
        $display("unused modes %0d, mismatches %0d",
                 mode_count[MODE_UNUSED_LO] + mode_count[MODE_UNUSED_MID]
                 + mode_count[MODE_UNUSED_HI], error_count);
        if (error_count == 0 && column_expect.size() == 0) begin
            $display("tb_led_matrix_frame_engine OK");
        end else begin
            $display("tb_led_matrix_frame_engine NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
